/* src/csvp_pkg.sv */
// Package for the CSV row field parser: codes, parse phases, result item type.
// No dependencies; the design files refer to it by scoped names, the test files import it.
`timescale 1ns / 1ps

package csvp_pkg;

	localparam int unsigned DATA_W          = 8;
	localparam int unsigned MODE_W          = 2;
	localparam int unsigned KIND_W          = 3;
	localparam int unsigned ERR_W           = 3;
	localparam int unsigned FNUM_W          = 11;
	localparam int unsigned COLS_W          = 11;
	localparam int unsigned CFG_IDX_W       = 2;
	localparam int unsigned CFG_DATA_W      = 11;
	localparam int unsigned MAX_COLUMNS_DEF = 1024;

	localparam logic [DATA_W-1:0] CH_CR  = 8'd13;
	localparam logic [DATA_W-1:0] CH_LF  = 8'd10;
	localparam logic [DATA_W-1:0] CH_NUL = 8'd0;

	localparam logic [DATA_W-1:0] DELIM_RST    = 8'd44;
	localparam logic [DATA_W-1:0] QUOTE_RST    = 8'd34;
	localparam logic [COLS_W-1:0] EXP_COLS_RST = 11'd0;

	localparam logic [CFG_IDX_W-1:0] REG_DELIM    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUOTE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXP_COLS = 2'd2;

	localparam logic [MODE_W-1:0] MODE_DATA = 2'd0;
	localparam logic [MODE_W-1:0] MODE_EOL  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EOF  = 2'd2;

	localparam logic [KIND_W-1:0] KIND_BYTE = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FEND = 3'd1;
	localparam logic [KIND_W-1:0] KIND_REND = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ERR  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_EOD  = 3'd4;

	localparam logic [ERR_W-1:0] ERR_NONE  = 3'd0;
	localparam logic [ERR_W-1:0] ERR_NULL  = 3'd1;
	localparam logic [ERR_W-1:0] ERR_TOKEN = 3'd2;
	localparam logic [ERR_W-1:0] ERR_QUOTE = 3'd3;
	localparam logic [ERR_W-1:0] ERR_COLS  = 3'd4;

	typedef enum logic [2:0] {
		PH_INITIAL    = 3'd0,
		PH_NEXT       = 3'd1,
		PH_REGULAR    = 3'd2,
		PH_QUOTING    = 3'd3,
		PH_QUOTE_SEEN = 3'd4,
		PH_EXPECT     = 3'd5,
		PH_SKIP       = 3'd6
	} phase_t;

	typedef struct packed {
		logic [DATA_W-1:0] delim;
		logic [DATA_W-1:0] quote;
		logic [COLS_W-1:0] exp_cols;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] out_byte;
		logic [FNUM_W-1:0] field_number;
		logic [ERR_W-1:0]  error_code;
		logic              last;
	} res_t;

endpackage

/* src/csvp_if.sv */
// Valid/ready channels of the CSV row field parser: input item and result item.
// Depends on csvp_pkg for the field widths.
`timescale 1ns / 1ps

interface csvp_in_if;
	logic                             valid;
	logic                             ready;
	logic [csvp_pkg::MODE_W-1:0]      mode;
	logic [csvp_pkg::DATA_W-1:0]      data_byte;

	modport source (output valid, output mode, output data_byte, input ready);
	modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface csvp_out_if;
	logic                             valid;
	logic                             ready;
	logic [csvp_pkg::KIND_W-1:0]      kind;
	logic [csvp_pkg::DATA_W-1:0]      out_byte;
	logic [csvp_pkg::FNUM_W-1:0]      field_number;
	logic [csvp_pkg::ERR_W-1:0]       error_code;
	logic                             last;

	modport source (output valid, output kind, output out_byte, output field_number,
		output error_code, output last, input ready);
	modport sink   (input valid, input kind, input out_byte, input field_number,
		input error_code, input last, output ready);
endinterface

/* src/csv_row_field_parser.sv */
// An accepted item is registered in the input register; its results are then written into
// the result queue once the queue has room, and the result port reads the queue.
// Throughput: one item per cycle while each gives at most one result and the queue has room;
// an item with two results needs the single result port for each (queue of four entries).
// Reset (arst_n, asynchronous, active low) clears the phase, field count, held CR,
// queue and input register, and loads the delimiter, quote and column defaults.
`timescale 1ns / 1ps

module csv_row_field_parser #(
	parameter int unsigned MAX_COLUMNS = csvp_pkg::MAX_COLUMNS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [csvp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [csvp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	csvp_in_if.sink                           in_ch,
	csvp_out_if.source                        out_ch
);

	localparam int unsigned CNT_W = $clog2(MAX_COLUMNS + 1);

	csvp_pkg::cfg_t   cfg_q;
	csvp_pkg::phase_t phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic             held_q;

	logic                          valid_s1;
	logic [csvp_pkg::MODE_W-1:0]   mode_s1;
	logic [csvp_pkg::DATA_W-1:0]   byte_s1;

	csvp_pkg::phase_t phase_nx;
	logic [CNT_W-1:0] cnt_nx;
	logic             held_nx;
	csvp_pkg::res_t   step_res [2];
	logic [1:0]       step_num;
	logic [1:0]       push_n;
	logic             room;
	logic             fire;
	logic             in_acc;

	assign fire        = valid_s1 && room;
	assign in_ch.ready = !valid_s1 || fire;
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign push_n      = fire ? step_num : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delim    <= csvp_pkg::DELIM_RST;
			cfg_q.quote    <= csvp_pkg::QUOTE_RST;
			cfg_q.exp_cols <= csvp_pkg::EXP_COLS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				csvp_pkg::REG_DELIM:    cfg_q.delim    <= cfg_wdata[csvp_pkg::DATA_W-1:0];
				csvp_pkg::REG_QUOTE:    cfg_q.quote    <= cfg_wdata[csvp_pkg::DATA_W-1:0];
				csvp_pkg::REG_EXP_COLS: cfg_q.exp_cols <= cfg_wdata[csvp_pkg::COLS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_s1 <= in_ch.mode;
			byte_s1 <= in_ch.data_byte;
		end
	end

	// advance the parse state once per item processed from the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= csvp_pkg::PH_INITIAL;
			cnt_q   <= '0;
			held_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_nx;
			cnt_q   <= cnt_nx;
			held_q  <= held_nx;
		end
	end

	csvp_step #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_step (
		.phase     (phase_q),
		.count     (cnt_q),
		.held      (held_q),
		.mode      (mode_s1),
		.data_byte (byte_s1),
		.cfg       (cfg_q),
		.phase_nx  (phase_nx),
		.count_nx  (cnt_nx),
		.held_nx   (held_nx),
		.res       (step_res),
		.num       (step_num)
	);

	csvp_res_fifo u_res_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.push_res (step_res),
		.room     (room),
		.out_ch   (out_ch)
	);

	a_skip_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == csvp_pkg::PH_SKIP) |-> (cnt_q == '0))
		else $error("field count not cleared while skipping a line");

	a_held_regular: assert property (@(posedge clk) disable iff (!arst_n)
		held_q |-> (phase_q == csvp_pkg::PH_REGULAR))
		else $error("carriage return held outside a regular field");

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_COLUMNS))
		else $error("field count beyond saturation limit");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(phase_q) && $stable(cnt_q) && $stable(held_q))
		else $error("parse state moved without an item");

endmodule

/* src/csvp_step.sv */
// Parser transition logic: from the current phase, field count and held CR plus
// one input item, gives the next state and up to two result items. Uses csvp_pkg.
`timescale 1ns / 1ps

module csvp_step #(
	parameter int unsigned MAX_COLUMNS = csvp_pkg::MAX_COLUMNS_DEF
) (
	input  csvp_pkg::phase_t                     phase,
	input  logic [$clog2(MAX_COLUMNS+1)-1:0]     count,
	input  logic                                 held,
	input  logic [csvp_pkg::MODE_W-1:0]          mode,
	input  logic [csvp_pkg::DATA_W-1:0]          data_byte,
	input  csvp_pkg::cfg_t                       cfg,
	output csvp_pkg::phase_t                     phase_nx,
	output logic [$clog2(MAX_COLUMNS+1)-1:0]     count_nx,
	output logic                                 held_nx,
	output csvp_pkg::res_t                       res [2],
	output logic [1:0]                           num
);

	localparam int unsigned CNT_W = $clog2(MAX_COLUMNS + 1);
	localparam int unsigned CMP_W = (CNT_W > csvp_pkg::COLS_W) ? CNT_W : csvp_pkg::COLS_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COLUMNS);

	function automatic csvp_pkg::res_t mk_res(
		input logic [csvp_pkg::KIND_W-1:0] kind,
		input logic [csvp_pkg::DATA_W-1:0] bval,
		input logic [CNT_W-1:0]            cval,
		input logic [csvp_pkg::ERR_W-1:0]  err
	);
		csvp_pkg::res_t r;
		r.kind         = kind;
		r.out_byte     = bval;
		r.field_number = (kind == csvp_pkg::KIND_EOD) ? '0 : csvp_pkg::FNUM_W'(cval);
		r.error_code   = err;
		r.last         = 1'b0;
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] c);
		return (c < CNT_MAX) ? c + 1'b1 : c;
	endfunction

	logic is_skip;
	logic is_nul;
	logic do_start;
	logic do_expect;
	logic do_close;
	logic take_b;
	logic cols_bad;

	always_comb begin
		phase_nx  = phase;
		count_nx  = count;
		held_nx   = held;
		num       = 2'd0;
		res[0]    = '0;
		res[1]    = '0;
		do_start  = 1'b0;
		do_expect = 1'b0;
		do_close  = 1'b0;
		take_b    = 1'b1;
		cols_bad  = 1'b0;
		is_skip   = (data_byte == csvp_pkg::CH_CR) || (data_byte == csvp_pkg::CH_LF);
		is_nul    = (data_byte == csvp_pkg::CH_NUL);

		if (mode == csvp_pkg::MODE_DATA) begin
			unique case (phase)
				csvp_pkg::PH_INITIAL, csvp_pkg::PH_NEXT: begin
					do_start = 1'b1;
				end
				csvp_pkg::PH_REGULAR: begin
					if (held) begin
						held_nx = 1'b0;
						if (cfg.delim == csvp_pkg::CH_CR) begin
							// held CR was a delimiter: close the field, restart on this byte
							res[num[0]] = mk_res(csvp_pkg::KIND_FEND, '0, count_nx,
								csvp_pkg::ERR_NONE);
							num      = num + 2'd1;
							count_nx = inc_sat(count_nx);
							phase_nx = csvp_pkg::PH_NEXT;
							do_start = 1'b1;
							take_b   = 1'b0;
						end else begin
							res[num[0]] = mk_res(csvp_pkg::KIND_BYTE, csvp_pkg::CH_CR,
								count_nx, csvp_pkg::ERR_NONE);
							num = num + 2'd1;
						end
					end
					if (take_b) begin
						if (data_byte == csvp_pkg::CH_CR) begin
							held_nx = 1'b1;
						end else if (data_byte == cfg.delim) begin
							res[num[0]] = mk_res(csvp_pkg::KIND_FEND, '0, count_nx,
								csvp_pkg::ERR_NONE);
							num      = num + 2'd1;
							count_nx = inc_sat(count_nx);
							phase_nx = csvp_pkg::PH_NEXT;
						end else begin
							res[num[0]] = mk_res(csvp_pkg::KIND_BYTE, data_byte, count_nx,
								csvp_pkg::ERR_NONE);
							num = num + 2'd1;
						end
					end
				end
				csvp_pkg::PH_QUOTING: begin
					if (!is_skip) begin
						if (is_nul) begin
							res[num[0]] = mk_res(csvp_pkg::KIND_ERR, '0, count_nx,
								csvp_pkg::ERR_NULL);
							num      = num + 2'd1;
							phase_nx = csvp_pkg::PH_SKIP;
							count_nx = '0;
							held_nx  = 1'b0;
						end else if (data_byte == cfg.quote) begin
							phase_nx = csvp_pkg::PH_QUOTE_SEEN;
						end else begin
							res[num[0]] = mk_res(csvp_pkg::KIND_BYTE, data_byte, count_nx,
								csvp_pkg::ERR_NONE);
							num = num + 2'd1;
						end
					end
				end
				csvp_pkg::PH_QUOTE_SEEN: begin
					if (data_byte == cfg.quote) begin
						res[num[0]] = mk_res(csvp_pkg::KIND_BYTE, data_byte, count_nx,
							csvp_pkg::ERR_NONE);
						num      = num + 2'd1;
						phase_nx = csvp_pkg::PH_QUOTING;
					end else begin
						res[num[0]] = mk_res(csvp_pkg::KIND_FEND, '0, count_nx,
							csvp_pkg::ERR_NONE);
						num       = num + 2'd1;
						count_nx  = inc_sat(count_nx);
						phase_nx  = csvp_pkg::PH_EXPECT;
						do_expect = 1'b1;
					end
				end
				csvp_pkg::PH_EXPECT: begin
					do_expect = 1'b1;
				end
				default: begin
				end
			endcase

			if (do_start && !is_skip) begin
				if (is_nul) begin
					res[num[0]] = mk_res(csvp_pkg::KIND_ERR, '0, count_nx, csvp_pkg::ERR_NULL);
					num      = num + 2'd1;
					phase_nx = csvp_pkg::PH_SKIP;
					count_nx = '0;
					held_nx  = 1'b0;
				end else if (data_byte == cfg.quote) begin
					phase_nx = csvp_pkg::PH_QUOTING;
				end else if (data_byte == cfg.delim) begin
					res[num[0]] = mk_res(csvp_pkg::KIND_FEND, '0, count_nx, csvp_pkg::ERR_NONE);
					num      = num + 2'd1;
					count_nx = inc_sat(count_nx);
					phase_nx = csvp_pkg::PH_NEXT;
				end else begin
					res[num[0]] = mk_res(csvp_pkg::KIND_BYTE, data_byte, count_nx,
						csvp_pkg::ERR_NONE);
					num      = num + 2'd1;
					phase_nx = csvp_pkg::PH_REGULAR;
				end
			end

			if (do_expect && !is_skip) begin
				if (!is_nul && data_byte == cfg.delim) begin
					phase_nx = csvp_pkg::PH_NEXT;
				end else begin
					res[num[0]] = mk_res(csvp_pkg::KIND_ERR, '0, count_nx,
						is_nul ? csvp_pkg::ERR_NULL : csvp_pkg::ERR_TOKEN);
					num      = num + 2'd1;
					phase_nx = csvp_pkg::PH_SKIP;
					count_nx = '0;
					held_nx  = 1'b0;
				end
			end
		end else if (mode == csvp_pkg::MODE_EOL) begin
			do_close = 1'b1;
		end else if (mode == csvp_pkg::MODE_EOF) begin
			if (phase == csvp_pkg::PH_INITIAL || phase == csvp_pkg::PH_SKIP) begin
				res[num[0]] = mk_res(csvp_pkg::KIND_EOD, '0, count_nx, csvp_pkg::ERR_NONE);
				num      = num + 2'd1;
				phase_nx = csvp_pkg::PH_INITIAL;
				count_nx = '0;
				held_nx  = 1'b0;
			end else if (phase == csvp_pkg::PH_QUOTING) begin
				res[num[0]] = mk_res(csvp_pkg::KIND_ERR, '0, count_nx, csvp_pkg::ERR_QUOTE);
				num      = num + 2'd1;
				phase_nx = csvp_pkg::PH_INITIAL;
				count_nx = '0;
				held_nx  = 1'b0;
			end else begin
				do_close = 1'b1;
			end
		end

		if (do_close) begin
			unique case (phase)
				csvp_pkg::PH_NEXT, csvp_pkg::PH_REGULAR, csvp_pkg::PH_QUOTE_SEEN: begin
					// close the open field, then the row; a held CR is dropped
					res[num[0]] = mk_res(csvp_pkg::KIND_FEND, '0, count_nx, csvp_pkg::ERR_NONE);
					num      = num + 2'd1;
					count_nx = inc_sat(count_nx);
				end
				default: begin
				end
			endcase
			unique case (phase)
				csvp_pkg::PH_INITIAL, csvp_pkg::PH_NEXT, csvp_pkg::PH_REGULAR,
				csvp_pkg::PH_QUOTE_SEEN, csvp_pkg::PH_EXPECT: begin
					cols_bad = (cfg.exp_cols != '0) &&
						(CMP_W'(count_nx) != CMP_W'(cfg.exp_cols));
					if (cols_bad) begin
						res[num[0]] = mk_res(csvp_pkg::KIND_ERR, '0, count_nx,
							csvp_pkg::ERR_COLS);
					end else begin
						res[num[0]] = mk_res(csvp_pkg::KIND_REND, '0, count_nx,
							csvp_pkg::ERR_NONE);
					end
					num      = num + 2'd1;
					phase_nx = csvp_pkg::PH_INITIAL;
					count_nx = '0;
					held_nx  = 1'b0;
				end
				csvp_pkg::PH_SKIP: begin
					phase_nx = csvp_pkg::PH_INITIAL;
					count_nx = '0;
					held_nx  = 1'b0;
				end
				default: begin
				end
			endcase
		end

		// mark the final result of the item
		if (num == 2'd1) begin
			res[0].last = 1'b1;
		end else if (num == 2'd2) begin
			res[1].last = 1'b1;
		end
	end

endmodule

/* src/csvp_res_fifo.sv */
// Four-entry result queue: takes up to two result items a cycle, hands out one.
// Uses csvp_pkg and the csvp_out_if channel.
`timescale 1ns / 1ps

module csvp_res_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_n,
	input  csvp_pkg::res_t    push_res [2],
	output logic              room,
	csvp_out_if.source        out_ch
);

	csvp_pkg::res_t mem_q [4];
	logic [1:0]     wr_ptr_q;
	logic [1:0]     rd_ptr_q;
	logic [2:0]     count_q;
	logic           pop;

	assign pop  = out_ch.valid && out_ch.ready;
	// registered room check: two free slots whatever the sink does
	assign room = (count_q <= 3'd2);

	assign out_ch.valid        = (count_q != 3'd0);
	assign out_ch.kind         = mem_q[rd_ptr_q].kind;
	assign out_ch.out_byte     = mem_q[rd_ptr_q].out_byte;
	assign out_ch.field_number = mem_q[rd_ptr_q].field_number;
	assign out_ch.error_code   = mem_q[rd_ptr_q].error_code;
	assign out_ch.last         = mem_q[rd_ptr_q].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push_res[0];
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + 2'd1] <= push_res[1];
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue count out of range");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> room)
		else $error("result pushed without room");

	a_push_max: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd3)
		else $error("more than two results pushed");

endmodule

/* test/csvp_parse_checker.sv */
// Result checker for the CSV row field parser: watches the config port and both channels,
// predicts the result items of every accepted input item and compares them in order.
// Depends on csvp_pkg and the channel interfaces in csvp_if.
`timescale 1ns / 1ps

module csvp_parse_checker import csvp_pkg::*; #(
	parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	csvp_in_if                    in_ch,
	csvp_out_if                   out_ch,
	output int unsigned           outstanding,
	output int unsigned           mismatches
);

	logic [DATA_W-1:0] sep_byte;
	logic [DATA_W-1:0] quote_byte;
	logic [COLS_W-1:0] want_cols;

	phase_t            phase;
	logic [COLS_W-1:0] col_count;
	logic              cr_held;

	res_t              csv_expect_q[$];
	int unsigned       bad_count;
	int unsigned       seen;

	task automatic report_mismatch(input string what);
		$display("%0t csvp_parse_checker: %s", $time, what);
		bad_count++;
	endtask

	task automatic check_field(input string name, input logic [10:0] got,
			input logic [10:0] want_v);
		if (got !== want_v)
			report_mismatch($sformatf("result %0d %s got %0h want %0h", seen, name, got,
				want_v));
	endtask

	function automatic void note_result(input logic [KIND_W-1:0] k,
			input logic [DATA_W-1:0] b, input logic [ERR_W-1:0] e);
		res_t r;
		r.kind         = k;
		r.out_byte     = b;
		r.field_number = (k == KIND_EOD) ? '0 : col_count;
		r.error_code   = e;
		r.last         = 1'b0;
		csv_expect_q = {csv_expect_q, r};
	endfunction

	function automatic void close_field();
		note_result(KIND_FEND, '0, ERR_NONE);
		if (col_count < MAX_COLUMNS)
			col_count = col_count + 1'b1;
	endfunction

	function automatic void clear_row(input phase_t p);
		phase     = p;
		col_count = '0;
		cr_held   = 1'b0;
	endfunction

	function automatic void raise_error(input logic [ERR_W-1:0] e, input phase_t p);
		note_result(KIND_ERR, '0, e);
		clear_row(p);
	endfunction

	function automatic void close_row();
		if (want_cols != '0 && col_count != want_cols)
			note_result(KIND_ERR, '0, ERR_COLS);
		else
			note_result(KIND_REND, '0, ERR_NONE);
		clear_row(PH_INITIAL);
	endfunction

	function automatic bit is_break(input logic [DATA_W-1:0] b);
		return b == CH_CR || b == CH_LF;
	endfunction

	// first byte of a field, or any byte while waiting for one
	function automatic void open_byte(input logic [DATA_W-1:0] b);
		if (is_break(b))
			return;
		if (b == CH_NUL) begin
			raise_error(ERR_NULL, PH_SKIP);
			return;
		end
		if (b == quote_byte) begin
			phase = PH_QUOTING;
		end else if (b == sep_byte) begin
			close_field();
			phase = PH_NEXT;
		end else begin
			phase = PH_REGULAR;
			note_result(KIND_BYTE, b, ERR_NONE);
		end
	endfunction

	function automatic void plain_byte(input logic [DATA_W-1:0] b);
		// a held CR is content unless it is itself the delimiter
		if (cr_held) begin
			cr_held = 1'b0;
			if (sep_byte == CH_CR) begin
				close_field();
				phase = PH_NEXT;
				open_byte(b);
				return;
			end
			note_result(KIND_BYTE, CH_CR, ERR_NONE);
		end
		if (b == CH_CR) begin
			cr_held = 1'b1;
		end else if (b == sep_byte) begin
			close_field();
			phase = PH_NEXT;
		end else begin
			note_result(KIND_BYTE, b, ERR_NONE);
		end
	endfunction

	function automatic void after_close_byte(input logic [DATA_W-1:0] b);
		if (is_break(b))
			return;
		if (b == CH_NUL)
			raise_error(ERR_NULL, PH_SKIP);
		else if (b == sep_byte)
			phase = PH_NEXT;
		else
			raise_error(ERR_TOKEN, PH_SKIP);
	endfunction

	function automatic void line_end();
		case (phase)
			PH_INITIAL, PH_EXPECT: close_row();
			PH_NEXT, PH_REGULAR, PH_QUOTE_SEEN: begin
				cr_held = 1'b0;
				close_field();
				close_row();
			end
			PH_QUOTING: ;
			default: clear_row(PH_INITIAL);
		endcase
	endfunction

	function automatic void predict_item(input logic [MODE_W-1:0] m,
			input logic [DATA_W-1:0] b);
		int unsigned n0;
		res_t        r;
		n0 = csv_expect_q.size();
		case (m)
			MODE_DATA: begin
				case (phase)
					PH_INITIAL, PH_NEXT: open_byte(b);
					PH_REGULAR: plain_byte(b);
					PH_QUOTING: begin
						if (!is_break(b)) begin
							if (b == CH_NUL)
								raise_error(ERR_NULL, PH_SKIP);
							else if (b == quote_byte)
								phase = PH_QUOTE_SEEN;
							else
								note_result(KIND_BYTE, b, ERR_NONE);
						end
					end
					PH_QUOTE_SEEN: begin
						if (b == quote_byte) begin
							note_result(KIND_BYTE, b, ERR_NONE);
							phase = PH_QUOTING;
						end else begin
							close_field();
							phase = PH_EXPECT;
							after_close_byte(b);
						end
					end
					PH_EXPECT: after_close_byte(b);
					default: ;
				endcase
			end
			MODE_EOL: line_end();
			MODE_EOF: begin
				if (phase == PH_INITIAL || phase == PH_SKIP) begin
					clear_row(PH_INITIAL);
					note_result(KIND_EOD, '0, ERR_NONE);
				end else if (phase == PH_QUOTING) begin
					raise_error(ERR_QUOTE, PH_INITIAL);
				end else begin
					line_end();
				end
			end
			default: ;
		endcase
		// mark the final result of this item
		if (csv_expect_q.size() > n0) begin
			r = csv_expect_q[csv_expect_q.size() - 1];
			r.last = 1'b1;
			csv_expect_q[csv_expect_q.size() - 1] = r;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			sep_byte   = DELIM_RST;
			quote_byte = QUOTE_RST;
			want_cols  = EXP_COLS_RST;
			clear_row(PH_INITIAL);
			csv_expect_q.delete();
			bad_count  = 0;
			seen       = 0;
			outstanding <= 0;
			mismatches  <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DELIM:    sep_byte   = cfg_wdata[DATA_W-1:0];
					REG_QUOTE:    quote_byte = cfg_wdata[DATA_W-1:0];
					REG_EXP_COLS: want_cols  = cfg_wdata[COLS_W-1:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				if (csv_expect_q.size() == 0) begin
					report_mismatch($sformatf("result %0d kind %0h with no item pending",
						seen, out_ch.kind));
				end else begin
					want = csv_expect_q.pop_front();
					check_field("kind", 11'(out_ch.kind), 11'(want.kind));
					check_field("out_byte", 11'(out_ch.out_byte), 11'(want.out_byte));
					check_field("field_number", out_ch.field_number, want.field_number);
					check_field("error_code", 11'(out_ch.error_code), 11'(want.error_code));
					check_field("last", 11'(out_ch.last), 11'(want.last));
				end
				seen++;
			end
			if (in_ch.valid && in_ch.ready)
				predict_item(in_ch.mode, in_ch.data_byte);
			outstanding <= csv_expect_q.size();
			mismatches  <= bad_count;
		end
	end

endmodule

/* test/tb_csv_row_field_parser.sv */
// Top of the CSV row field parser testbench: clock, reset, config writes and item stimulus.
// Depends on csvp_pkg, csvp_if, the parser and csvp_parse_checker, which does the checking.
`timescale 1ns / 1ps

module tb_csv_row_field_parser;
	import csvp_pkg::*;

	localparam int unsigned         CYCLE_LIMIT = 400000;
	localparam logic [MODE_W-1:0]   MODE_VOID   = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int unsigned outstanding;
	int unsigned mismatches;
	int unsigned src_idle_pct = 12;
	int unsigned snk_idle_pct = 60;
	int unsigned items_sent   = 0;

	logic [DATA_W-1:0] cur_delim;
	logic [DATA_W-1:0] cur_quote;
	logic [COLS_W-1:0] cur_cols;

	csvp_in_if  in_ch();
	csvp_out_if out_ch();

	csv_row_field_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	csvp_parse_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_csv_row_field_parser: errors");
		$finish;
	end

	task automatic send_item(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.mode      <= m;
		in_ch.data_byte <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (m != MODE_VOID)
			items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(MODE_DATA, s[i]);
	endtask

	// drop valid, let the queue empty and any result-free item finish
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(input logic [DATA_W-1:0] d, input logic [DATA_W-1:0] q,
			input logic [COLS_W-1:0] cols);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DELIM;
		cfg_wdata <= CFG_DATA_W'(d);
		@(posedge clk);
		cfg_index <= REG_QUOTE;
		cfg_wdata <= CFG_DATA_W'(q);
		@(posedge clk);
		cfg_index <= REG_EXP_COLS;
		cfg_wdata <= CFG_DATA_W'(cols);
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_delim = d;
		cur_quote = q;
		cur_cols  = cols;
	endtask

	// content byte that keeps a field well formed
	function automatic logic [DATA_W-1:0] pick_byte(input bit in_quotes);
		logic [DATA_W-1:0] b;
		do begin
			b = DATA_W'($urandom_range(255));
		end while (b == cur_quote || b == CH_NUL ||
			(!in_quotes && (b == cur_delim || b == CH_CR || b == CH_LF)));
		return b;
	endfunction

	// byte biased towards the ones the parser treats specially
	function automatic logic [DATA_W-1:0] any_byte();
		case ($urandom_range(9))
			0: return cur_delim;
			1: return cur_quote;
			2: return CH_CR;
			3: return CH_LF;
			4: return CH_NUL;
			default: return DATA_W'($urandom_range(255));
		endcase
	endfunction

	function automatic int pick_cols();
		if (cur_cols != 0 && cur_cols <= 8 && $urandom_range(9) < 8)
			return cur_cols;
		return $urandom_range(0, 6);
	endfunction

	task automatic send_field();
		int style;
		int len;
		style = $urandom_range(9);
		len   = $urandom_range(0, 5);
		if (style < 6) begin
			repeat (len) begin
				// a CR followed by more content stays in the field unless CR is the delimiter
				if ($urandom_range(11) == 0)
					send_item(MODE_DATA, CH_CR);
				send_item(MODE_DATA, pick_byte(1'b0));
			end
		end else begin
			send_item(MODE_DATA, cur_quote);
			repeat (len) begin
				case ($urandom_range(15))
					0: begin
						send_item(MODE_DATA, cur_quote);
						send_item(MODE_DATA, cur_quote);
					end
					1: send_item(MODE_EOL, '0);
					2: send_item(MODE_DATA, cur_delim);
					default: send_item(MODE_DATA, pick_byte(1'b1));
				endcase
			end
			send_item(MODE_DATA, cur_quote);
		end
	endtask

	task automatic send_row(input int ncols);
		for (int i = 0; i < ncols; i++) begin
			if (i > 0)
				send_item(MODE_DATA, cur_delim);
			send_field();
		end
		case ($urandom_range(19))
			0: begin
				send_item(MODE_DATA, CH_CR);
				send_item(MODE_EOL, '0);
			end
			1: send_item(MODE_EOF, '0);
			default: send_item(MODE_EOL, '0);
		endcase
	endtask

	task automatic send_broken_row();
		int n;
		n = $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			send_field();
			send_item(MODE_DATA, cur_delim);
		end
		case ($urandom_range(3))
			0: send_item(MODE_DATA, CH_NUL);
			1: begin
				send_item(MODE_DATA, cur_quote);
				send_item(MODE_DATA, pick_byte(1'b1));
				send_item(MODE_DATA, cur_quote);
				send_item(MODE_DATA, any_byte());
			end
			2: begin
				// quote left open at end of file
				send_item(MODE_DATA, cur_quote);
				send_item(MODE_DATA, pick_byte(1'b1));
				send_item(MODE_EOF, '0);
				return;
			end
			default: send_item(MODE_DATA, any_byte());
		endcase
		repeat ($urandom_range(0, 4)) send_item(MODE_DATA, any_byte());
		send_item(($urandom_range(7) == 0) ? MODE_EOF : MODE_EOL, '0);
	endtask

	task automatic random_traffic(input int unsigned count);
		int unsigned target;
		int          r;
		target = items_sent + count;
		while (items_sent < target) begin
			r = $urandom_range(99);
			if (r < 70)
				send_row(pick_cols());
			else if (r < 85)
				send_broken_row();
			else
				repeat ($urandom_range(1, 8))
					send_item(MODE_W'($urandom_range(3)), any_byte());
		end
	endtask

	initial begin
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= REG_DELIM;
		cfg_wdata       <= '0;
		in_ch.valid     <= 1'b0;
		in_ch.mode      <= MODE_DATA;
		in_ch.data_byte <= '0;
		cur_delim = DELIM_RST;
		cur_quote = QUOTE_RST;
		cur_cols  = EXP_COLS_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on the reset settings
		send_item(MODE_EOL, '0);
		send_item(MODE_DATA, 8'hFF);
		send_text("a\rb,");
		send_text("\",\"\"\"\r,");
		send_text("\"q");
		send_item(MODE_EOL, '0);
		send_text("r\"xy");
		send_item(MODE_EOF, '0);
		send_text("c\r");
		send_item(MODE_EOL, '0);
		send_text("\"\"");
		send_item(MODE_DATA, CH_NUL);
		send_item(MODE_EOL, '0);
		send_text("\"w");
		send_item(MODE_EOF, '0);
		send_item(MODE_EOF, '0);
		send_item(MODE_VOID, 8'h5A);
		send_text("k");
		send_item(MODE_EOF, '0);

		settle();
		set_regs(8'd44, 8'd34, 11'd2);
		send_text("a,b");
		send_item(MODE_EOL, '0);
		send_text("a");
		send_item(MODE_EOL, '0);
		random_traffic(150);

		settle();
		set_regs(CH_CR, 8'hFF, 11'd0);
		random_traffic(150);

		settle();
		src_idle_pct = 60;
		snk_idle_pct = 12;
		set_regs(8'hFF, 8'h00, 11'd1024);
		// more fields than the count can hold
		repeat (1100) send_item(MODE_DATA, cur_delim);
		send_item(MODE_EOL, '0);
		random_traffic(100);

		settle();
		set_regs(8'h00, 8'd39, 11'd3);
		random_traffic(150);

		settle();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		set_regs(DATA_W'($urandom_range(255)), DATA_W'($urandom_range(255)),
			COLS_W'($urandom_range(5)));
		random_traffic(150);

		settle();
		set_regs(DATA_W'($urandom_range(255)), DATA_W'($urandom_range(255)),
			COLS_W'($urandom_range(5)));
		random_traffic(150);
		send_item(MODE_EOF, '0);
		send_item(MODE_EOF, '0);

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb_csv_row_field_parser: clean");
		else
			$display("tb_csv_row_field_parser: errors");
		$finish;
	end

endmodule
